@@ hw/rtl/sts_pkg.sv @@
// Shared types and constants for the sorted table search block.
// Used by the channel interfaces, the front end, the back end and the top level.
`timescale 1ns / 1ps

package sts_pkg;

	localparam int OP_W        = 1;
	localparam int IDX_W       = 5;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QFILL_W     = 2;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_e;

	typedef struct packed {
		logic             search;
		logic             wr_en;
		logic [IDX_W-1:0] index;
		data_t            data;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_RESULT
	} state_t;

endpackage

@@ hw/rtl/sts_req_if.sv @@
// Request channel of the sorted table search block.
// Depends on sts_pkg for the field widths.
`timescale 1ns / 1ps

interface sts_req_if;
	logic                          valid;
	logic                          ready;
	logic [sts_pkg::OP_W-1:0]      operation;
	logic [sts_pkg::IDX_W-1:0]     entry_index;
	logic signed [sts_pkg::DATA_W-1:0] entry_value;
	logic signed [sts_pkg::DATA_W-1:0] search_key;

	modport source (output valid, output operation, output entry_index,
		output entry_value, output search_key, input ready);
	modport sink (input valid, input operation, input entry_index,
		input entry_value, input search_key, output ready);
endinterface

@@ hw/rtl/sts_rsp_if.sv @@
// Result channel of the sorted table search block.
// Depends on sts_pkg for the field widths.
`timescale 1ns / 1ps

interface sts_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [sts_pkg::IDX_W-1:0] position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

@@ hw/rtl/sts_cfg_if.sv @@
// Configuration write channel carrying the entry count register.
// Depends on sts_pkg for the register width.
`timescale 1ns / 1ps

interface sts_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [sts_pkg::CNT_W-1:0] entry_count;

	modport source (output valid, output entry_count, input ready);
	modport sink (input valid, input entry_count, output ready);
endinterface

@@ hw/rtl/sts_front.sv @@
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on sts_pkg and sts_req_if.
`timescale 1ns / 1ps

module sts_front #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sts_req_if.sink       req,
	output logic          q_valid,
	output sts_pkg::cmd_t q_cmd,
	input  logic          q_pop
);

	sts_pkg::cmd_t                  slot_q [sts_pkg::QUEUE_DEPTH];
	logic                           wr_ptr_q;
	logic                           rd_ptr_q;
	logic [sts_pkg::QFILL_W-1:0]    fill_q;
	sts_pkg::cmd_t                  in_cmd;
	logic                           push;

	assign req.ready = (fill_q != sts_pkg::QFILL_W'(sts_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (fill_q != '0);
	assign q_cmd     = slot_q[rd_ptr_q];

	// Writes beyond the table get wr_en cleared here, so the back end pops them without storing.
	always_comb begin
		in_cmd.search = (req.operation == sts_pkg::OP_SEARCH);
		in_cmd.wr_en  = !in_cmd.search && (32'(req.entry_index) < DEPTH);
		in_cmd.index  = req.entry_index;
		in_cmd.data   = in_cmd.search ? req.search_key : req.entry_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/sts_back.sv @@
// Back end: table memory, entry count register, probe sequencer and result register.
// Depends on sts_pkg, sts_rsp_if and sts_cfg_if.
`timescale 1ns / 1ps

module sts_back #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sts_pkg::cmd_t q_cmd,
	output logic          q_pop,
	sts_rsp_if.source     rsp,
	sts_cfg_if.sink       cfg
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sts_pkg::data_t               mem [DEPTH];
	sts_pkg::data_t               rd_data_q;
	sts_pkg::data_t               key_q;
	logic [sts_pkg::CNT_W-1:0]    count_q;
	logic [sts_pkg::CNT_W-1:0]    lo_q;
	logic [sts_pkg::CNT_W-1:0]    end_q;
	logic [sts_pkg::CNT_W-1:0]    mid_q;
	logic                         res_found_q;
	logic [sts_pkg::IDX_W-1:0]    res_pos_q;
	logic                         rsp_valid_q;
	logic                         rsp_found_q;
	logic [sts_pkg::IDX_W-1:0]    rsp_position_q;
	sts_pkg::state_t              state_q;
	sts_pkg::state_t              state_n;

	logic                         mem_we;
	logic [AW-1:0]                rd_addr;
	logic                         start_load;
	logic                         probe_load;
	logic                         res_load;
	logic                         res_found_n;
	logic [sts_pkg::IDX_W-1:0]    res_pos_n;
	logic                         out_load;
	logic                         lt;
	logic                         gt;
	logic [sts_pkg::CNT_W-1:0]    lo_n;
	logic [sts_pkg::CNT_W-1:0]    end_n;
	logic [sts_pkg::CNT_W-1:0]    mid_n;
	logic [sts_pkg::CNT_W-1:0]    mid_first;
	logic [sts_pkg::CNT_W:0]      mid_sum;
	logic [sts_pkg::CNT_W-1:0]    cfg_sat;

	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.position = rsp_position_q;

	assign cfg_sat = (32'(cfg.entry_count) > DEPTH) ? sts_pkg::CNT_W'(DEPTH)
		: cfg.entry_count;

	assign lt      = (key_q < rd_data_q);
	assign gt      = (rd_data_q < key_q);
	assign lo_n    = gt ? (mid_q + 1'b1) : lo_q;
	assign end_n   = lt ? mid_q : end_q;
	assign mid_sum = {1'b0, lo_n} + {1'b0, end_n} - 1'b1;
	assign mid_n   = mid_sum[sts_pkg::CNT_W:1];
	assign mid_first = 6'((count_q - 1'b1) >> 1);

	always_comb begin
		state_n     = state_q;
		q_pop       = 1'b0;
		mem_we      = 1'b0;
		rd_addr     = AW'(mid_first);
		start_load  = 1'b0;
		probe_load  = 1'b0;
		res_load    = 1'b0;
		res_found_n = 1'b0;
		res_pos_n   = '0;
		out_load    = 1'b0;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (!q_cmd.search) begin
						mem_we = q_cmd.wr_en;
					end else if (count_q == '0) begin
						res_load = 1'b1;
						state_n  = sts_pkg::ST_RESULT;
					end else begin
						start_load = 1'b1;
						state_n    = sts_pkg::ST_PROBE;
					end
				end
			end
			sts_pkg::ST_PROBE: begin
				rd_addr = AW'(mid_n);
				if (!lt && !gt) begin
					res_load    = 1'b1;
					res_found_n = 1'b1;
					res_pos_n   = sts_pkg::IDX_W'(mid_q);
					state_n     = sts_pkg::ST_RESULT;
				end else if (lo_n >= end_n) begin
					res_load = 1'b1;
					state_n  = sts_pkg::ST_RESULT;
				end else begin
					probe_load = 1'b1;
				end
			end
			sts_pkg::ST_RESULT: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_n  = sts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(q_cmd.index)] <= q_cmd.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start_load) begin
			key_q <= q_cmd.data;
			lo_q  <= '0;
			end_q <= count_q;
			mid_q <= mid_first;
		end else if (probe_load) begin
			lo_q  <= lo_n;
			end_q <= end_n;
			mid_q <= mid_n;
		end
		if (res_load) begin
			res_found_q <= res_found_n;
			res_pos_q   <= res_pos_n;
		end
		if (out_load) begin
			rsp_found_q    <= res_found_q;
			rsp_position_q <= res_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sts_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= sts_pkg::CNT_W'(1);
		end else begin
			state_q <= state_n;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				count_q <= cfg_sat;
			end
		end
	end

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
// Top level of the sorted table search block: front end, command queue and back end.
// Depends on sts_pkg, the three channel interfaces, sts_front and sts_back.
`timescale 1ns / 1ps

// A write request stores one signed value in the table; writes at an index of DEPTH
// or more are dropped. A search request binary-searches the first entry_count
// entries, which must be sorted ascending, and returns one result with a found flag
// and the matching index (0 when the key is absent). A search makes P probes, at
// most floor(log2(entry_count)) + 1, each one read through the single registered
// read port of the table. A two-entry command queue lets requests be taken while a
// search runs or a result waits. The table contents are undefined until written.
module sorted_table_binary_search #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sts_req_if.sink   req,
	sts_rsp_if.source rsp,
	sts_cfg_if.sink   cfg
);

	logic          q_valid;
	logic          q_pop;
	sts_pkg::cmd_t q_cmd;

	sts_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_valid(q_valid),
		.q_cmd  (q_cmd),
		.q_pop  (q_pop)
	);

	sts_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_cmd  (q_cmd),
		.q_pop  (q_pop),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule
